// ===== rtl/swq_pkg.sv =====
// Package for the semaphore wait-queue table: widths, codes and FSM states.
// No dependencies.
package swq_pkg;
	localparam int MaxProcs = 16;
	localparam int PW = $clog2(MaxProcs);
	localparam int KeyW = 32;

	typedef enum logic [1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_HEAD = 2'd2,
		REQ_REM  = 2'd3
	} req_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WALK,
		S_EXEC,
		S_OUT
	} state_t;
endpackage

// ===== rtl/swq_if.sv =====
// Valid/ready channel interfaces for the wait-queue table.
// Depends on swq_pkg.
interface swq_req_if import swq_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    req_type;
	logic [KeyW-1:0] sem_key_in;
	logic [3:0]    proc_in;
	modport source (output valid, req_type, sem_key_in, proc_in, input ready);
	modport sink   (input valid, req_type, sem_key_in, proc_in, output ready);
endinterface

interface swq_rsp_if ();
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] proc_out;
	modport source (output valid, status, proc_out, input ready);
	modport sink   (input valid, status, proc_out, output ready);
endinterface

// ===== rtl/semaphore_wait_queue_table.sv =====
// Semaphore wait-queue table top level: descriptor/process memories and sequencer.
// Depends on swq_pkg and swq_if.
//
//  channel  | dir | payload                         | handshake
//  req      | in  | req_type, sem_key_in, proc_in   | valid/ready
//  rsp      | out | status, proc_out                | valid/ready
//
// One item at a time. Key lookup sweeps the descriptor memory one entry a
// cycle; remove walks the waiter links one process at a time. Reset clears
// the act_q (descriptor active) and blk_q (process blocked) flags at once.
// A result waits in the output register; the next item is taken in the cycle
// after the result leaves.
module semaphore_wait_queue_table import swq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	swq_req_if.sink      req,
	swq_rsp_if.source    rsp
);
	// descriptor memory: {key, first, last}; process memory: {link, desc}
	logic [KeyW+2*PW-1:0] dmem [MaxProcs];
	logic [2*PW-1:0]      pmem [MaxProcs];
	logic [MaxProcs-1:0]  act_q, blk_q;

	state_t st_q, st_d;
	req_t   rt_q;
	logic [KeyW-1:0] key_q;
	logic [PW-1:0]   p_q;
	logic            pin_ok_q;

	// scan/walk bookkeeping
	logic [PW:0]   cnt_q;     // scan index, one bit wider to hold MaxProcs
	logic          hit_q;     // key match found
	logic [PW-1:0] hit_d_q;   // matched descriptor
	logic [PW-1:0] dd_q;      // descriptor in use for remove
	logic [PW-1:0] first_q, last_q;
	logic [PW-1:0] cur_q, prev_q;
	logic          prev_v_q, found_q;
	logic [PW-1:0] link_cur_q;

	// memory read ports
	logic [PW-1:0]        draddr, praddr;
	logic [KeyW+2*PW-1:0] drd_q;
	logic [2*PW-1:0]      prd_q;
	logic [PW-1:0]        draddr_q;
	logic                 drv_q;

	logic [1:0]    stat_q;
	logic [PW-1:0] pout_q;

	// lowest free descriptor
	logic          free_v;
	logic [PW-1:0] free_i;
	always_comb begin
		free_v = 1'b0;
		free_i = '0;
		for (int i = MaxProcs-1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_v = 1'b1;
				free_i = PW'(i);
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (req.valid) st_d = S_SCAN;
			S_SCAN: if (cnt_q == (PW+1)'(MaxProcs)) st_d = (rt_q == REQ_REM) ? S_WALK : S_EXEC;
			S_WALK: if (cnt_q == (PW+1)'(MaxProcs)) st_d = S_EXEC;
			S_EXEC: st_d = S_OUT;
			S_OUT:  if (rsp.ready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (st_q == S_IDLE);
		rsp.valid = (st_q == S_OUT);
	end
	assign rsp.status   = stat_q;
	assign rsp.proc_out = 4'(pout_q);

	// read addresses: scan sweeps descriptors; remove walks processes
	always_comb begin
		draddr = cnt_q[PW-1:0];
		praddr = (st_q == S_WALK) ? cur_q : p_q;
		if (rt_q == REQ_REM) draddr = dd_q;
	end

	always_ff @(posedge clk) begin
		drd_q    <= dmem[draddr];
		prd_q    <= pmem[praddr];
		draddr_q <= draddr;
	end

	// write side (only in S_EXEC)
	logic          dwe, pwe, pwe2;
	logic [PW-1:0] dwa, pwa, pwa2;
	logic [KeyW+2*PW-1:0] dwd;
	logic [2*PW-1:0] pwd, pwd2;
	logic [MaxProcs-1:0] act_d, blk_d;
	logic [1:0]    stat_d;
	logic [PW-1:0] pout_d;
	logic [KeyW-1:0] hkey;
	logic [PW-1:0] hfirst, hlast;

	always_comb begin
		{hkey, hfirst, hlast} = drd_q;
	end

	always_comb begin
		dwe = 1'b0; pwe = 1'b0; pwe2 = 1'b0;
		dwa = hit_d_q; pwa = p_q; pwa2 = '0;
		dwd = '0; pwd = '0; pwd2 = '0;
		act_d = act_q; blk_d = blk_q;
		stat_d = ST_MISSING; pout_d = '0;
		if (st_q == S_EXEC) begin
			unique case (rt_q)
				REQ_ENQ: begin
					if (pin_ok_q && !blk_q[p_q]) begin
						if (hit_q) begin
							dwe = 1'b1; dwa = hit_d_q;
							dwd = {key_q, first_q, p_q};
							pwe2 = 1'b1; pwa2 = last_q;
							pwd2 = {p_q, hit_d_q};
							pwe = 1'b1; pwd = {p_q, hit_d_q};
							blk_d[p_q] = 1'b1;
							stat_d = ST_OK; pout_d = p_q;
						end else if (free_v) begin
							dwe = 1'b1; dwa = free_i;
							dwd = {key_q, p_q, p_q};
							act_d[free_i] = 1'b1;
							pwe = 1'b1; pwd = {p_q, free_i};
							blk_d[p_q] = 1'b1;
							stat_d = ST_OK; pout_d = p_q;
						end else begin
							stat_d = ST_FULL;
						end
					end
				end
				REQ_DEQ, REQ_HEAD: begin
					if (hit_q) begin
						stat_d = ST_OK; pout_d = first_q;
						if (rt_q == REQ_DEQ) begin
							blk_d[first_q] = 1'b0;
							if (first_q == last_q) act_d[hit_d_q] = 1'b0;
							else begin
								dwe = 1'b1; dwa = hit_d_q;
								dwd = {key_q, link_cur_q, last_q};
							end
						end
					end
				end
				REQ_REM: begin
					if (found_q) begin
						stat_d = ST_OK; pout_d = p_q;
						blk_d[p_q] = 1'b0;
						if (first_q == p_q && last_q == p_q) act_d[dd_q] = 1'b0;
						else begin
							dwe = 1'b1; dwa = dd_q;
							dwd = {key_q,
								prev_v_q ? first_q : link_cur_q,
								(p_q == last_q && prev_v_q) ? prev_q : last_q};
							if (prev_v_q) begin
								pwe2 = 1'b1; pwa2 = prev_q;
								pwd2 = {link_cur_q, dd_q};
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// process memory has two writes only on enqueue append (link of last,
	// desc of new); merge as field writes of two entries over one port each
	logic [PW-1:0] plink [MaxProcs];
	logic [PW-1:0] pdesc [MaxProcs];
	always_ff @(posedge clk) begin
		if (dwe) dmem[dwa] <= dwd;
		if (pwe) pdesc[pwa] <= pwd[PW-1:0];
		if (pwe2) plink[pwa2] <= pwd2[2*PW-1:PW];
	end
	always_comb begin
		for (int i = 0; i < MaxProcs; i++) pmem[i] = {plink[i], pdesc[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			act_q <= '0;
			blk_q <= '0;
			drv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			act_q <= act_d;
			blk_q <= blk_d;
			drv_q <= (st_q == S_SCAN) || (st_q == S_WALK);
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				rt_q     <= req_t'(req.req_type);
				key_q    <= req.sem_key_in;
				p_q      <= PW'(req.proc_in);
				pin_ok_q <= (32'(req.proc_in) < 32'(MaxProcs));
				cnt_q    <= '0;
				hit_q    <= 1'b0;
				found_q  <= 1'b0;
				prev_v_q <= 1'b0;
			end
			S_SCAN: begin
				if (cnt_q == (PW+1)'(MaxProcs)) cnt_q <= '0;
				else cnt_q <= cnt_q + 1'b1;
				if (rt_q == REQ_REM) begin
					// first cycle reads pmem[p]; then dmem[dd]
					if (cnt_q == '0) begin
						dd_q <= '0;
					end else if (cnt_q == (PW+1)'(1)) begin
						dd_q <= prd_q[PW-1:0];
					end else if (cnt_q == (PW+1)'(3)) begin
						{key_q, first_q, last_q} <= drd_q;
						cur_q <= drd_q[2*PW-1:PW];
					end
				end else begin
					if (drv_q && !hit_q && act_q[draddr_q] && hkey == key_q) begin
						hit_q <= 1'b1;
						hit_d_q <= draddr_q;
						first_q <= hfirst;
						last_q <= hlast;
						// dequeue needs the link of the head
						link_cur_q <= plink[hfirst];
					end
				end
			end
			S_WALK: begin
				// cur_q presented; link available next cycle, so step only when cnt_q is odd
				if (!blk_q[p_q] || !pin_ok_q || !act_q[dd_q]) begin
					cnt_q <= (PW+1)'(MaxProcs);
				end else if (!found_q && cnt_q[0]) begin
					if (cur_q == p_q) begin
						found_q <= 1'b1;
						link_cur_q <= prd_q[2*PW-1:PW];
						cnt_q <= (PW+1)'(MaxProcs);
					end else if (cur_q == last_q) begin
						cnt_q <= (PW+1)'(MaxProcs);
					end else begin
						prev_q <= cur_q;
						prev_v_q <= 1'b1;
						cur_q <= prd_q[2*PW-1:PW];
						cnt_q <= '0;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_EXEC: begin
				stat_q <= stat_d;
				pout_q <= pout_d;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/swq_checker.sv =====
// Port-level checker for the wait-queue table, bound to the top level.
// Depends on swq_pkg.
module swq_checker import swq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] status,
	input logic [3:0] proc_out
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("input taken while result pending");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_FULL || status == ST_MISSING))
		else $error("bad status");
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> proc_out == 4'd0) else $error("proc_out on fail");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(status) && $stable(proc_out))
		else $error("result dropped");
endmodule

bind semaphore_wait_queue_table swq_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.status(rsp.status), .proc_out(rsp.proc_out)
);
